@@ rtl/tgr_pkg.sv @@
package tgr_pkg;

	localparam int MAX_FINGERS   = 8;
	localparam int COORD_BITS    = 12;
	localparam int ID_BITS       = 16;
	localparam int IDX_BITS      = $clog2(MAX_FINGERS);
	localparam int TC_BITS       = $clog2(MAX_FINGERS + 1);
	localparam int RAW_BITS      = 8;
	localparam int WIN_BITS      = 13;
	localparam int THR_BITS      = 10;
	localparam int TICK_BITS     = 16;
	localparam int DIR_BITS      = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// derived arithmetic widths
	localparam int DX_BITS     = COORD_BITS + WIN_BITS;
	localparam int SQ_BITS     = 2 * DX_BITS + 1;
	localparam int RT_BITS     = THR_BITS + COORD_BITS;
	localparam int SUM_BITS    = COORD_BITS + TC_BITS;
	localparam int REM_BITS    = TC_BITS + 1;
	localparam int DIVCNT_BITS = $clog2(SUM_BITS);
	localparam int MAX_RES     = 4;
	localparam int NRES_BITS   = 3;

	typedef enum logic [1:0] {
		ACT_DOWN,
		ACT_MOTION,
		ACT_UP,
		ACT_TICK
	} action_t;

	typedef enum logic [2:0] {
		K_MOVE,
		K_PRESS,
		K_RELEASE,
		K_SCROLL,
		K_RERAISE
	} kind_t;

	typedef enum logic [2:0] {
		G_IDLE,
		G_PENDING,
		G_TWO,
		G_PANNING,
		G_DRAGGING,
		G_CANCELLED
	} gesture_t;

	localparam logic [DIR_BITS-1:0] DIR_NONE = 4'd0;
	localparam logic [DIR_BITS-1:0] DIR_N    = 4'd1;
	localparam logic [DIR_BITS-1:0] DIR_NE   = 4'd2;
	localparam logic [DIR_BITS-1:0] DIR_E    = 4'd3;
	localparam logic [DIR_BITS-1:0] DIR_SE   = 4'd4;
	localparam logic [DIR_BITS-1:0] DIR_S    = 4'd5;
	localparam logic [DIR_BITS-1:0] DIR_SW   = 4'd6;
	localparam logic [DIR_BITS-1:0] DIR_W    = 4'd7;
	localparam logic [DIR_BITS-1:0] DIR_NW   = 4'd8;

	localparam logic BTN_LEFT  = 1'b0;
	localparam logic BTN_RIGHT = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_W      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_H      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_THR   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TWO_THR    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_STEP   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TICKS = 3'd5;

	typedef struct packed {
		logic [ID_BITS-1:0]    id;
		logic [COORD_BITS-1:0] down_x;
		logic [COORD_BITS-1:0] down_y;
		logic [COORD_BITS-1:0] cur_x;
		logic [COORD_BITS-1:0] cur_y;
	} finger_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  button;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  on;
		logic [DIR_BITS-1:0]   dir;
	} result_t;

	function automatic result_t mk_res(kind_t k, logic btn, logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y, logic on, logic [DIR_BITS-1:0] dir);
		result_t r;
		r.kind   = k;
		r.button = btn;
		r.x      = x;
		r.y      = y;
		r.on     = on;
		r.dir    = dir;
		return r;
	endfunction

	function automatic logic [COORD_BITS-1:0] absdiff(logic [COORD_BITS-1:0] a,
			logic [COORD_BITS-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ rtl/touch_gesture_recognizer_top.sv @@
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// input     | in_valid / in_ready  | action, direct_device, finger_id, touch_x, touch_y
// output    | out_valid / out_ready| kind, button, pos_x, pos_y, scroll_on, scroll_dir, last
// config    | cfg_wr_en            | cfg_index, cfg_data
//
// One event at a time over n tracked fingers: a tick or a plain down is handled directly,
// the third finger down walks the centroid and runs the 16-step divider, and a motion
// while panning does an id search and a centroid sum (each a table walk over the single
// read port), the 16-step divider and 5 distance steps.
// Each result then passes through the output register.
// Reset clears control state at once; the finger table needs no clearing pass.
// A stalled output holds the result register; a new event is taken once the
// previous one has handed all of its results to the output register.
module touch_gesture_recognizer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tgr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tgr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic                              direct_device,
	input  logic [tgr_pkg::ID_BITS-1:0]       finger_id,
	input  logic [tgr_pkg::COORD_BITS-1:0]    touch_x,
	input  logic [tgr_pkg::COORD_BITS-1:0]    touch_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        kind,
	output logic                              button,
	output logic [tgr_pkg::COORD_BITS-1:0]    pos_x,
	output logic [tgr_pkg::COORD_BITS-1:0]    pos_y,
	output logic                              scroll_on,
	output logic [tgr_pkg::DIR_BITS-1:0]      scroll_dir,
	output logic                              last
);
	import tgr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_FIND_RD,
		S_FIND_CHK,
		S_AFTER_FIND,
		S_CEN_RD,
		S_CEN_ADD,
		S_DIV,
		S_CEN_DONE,
		S_DIST,
		S_M_PEND,
		S_M_TWO,
		S_M_PAN,
		S_LEFT_RD,
		S_LEFT_CHK,
		S_U_TWO,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_LIFT_END,
		S_DRAIN
	} state_t;

	// finger table memory
	finger_t ftab [MAX_FINGERS];
	finger_t rd_q;
	finger_t wr_data;
	logic    wr_en;
	logic [IDX_BITS-1:0] wr_addr;
	logic [IDX_BITS-1:0] rd_addr;

	state_t   state_q;
	gesture_t gest_q;
	logic [RAW_BITS-1:0]   raw_q;
	logic [TC_BITS-1:0]    tc_q;
	logic [COORD_BITS-1:0] ppx_q, ppy_q;
	logic [TICK_BITS-1:0]  idle_q;
	logic                  sact_q;
	logic [DIR_BITS-1:0]   sdir_q;

	logic [WIN_BITS-1:0]  win_w_q, win_h_q;
	logic [THR_BITS-1:0]  drag_thr_q, two_thr_q, pan_step_q;
	logic [TICK_BITS-1:0] idle_ticks_q;

	action_t               act_q;
	logic                  dev_q;
	logic [ID_BITS-1:0]    fid_q;
	logic [COORD_BITS-1:0] tx_q, ty_q;

	logic [TC_BITS-1:0]  walk_q;
	logic                found_q;
	logic [IDX_BITS-1:0] fidx_q;
	finger_t             ent_q;
	logic [COORD_BITS-1:0] lx_q, ly_q;

	logic [SUM_BITS-1:0]    sx_q, sy_q;
	logic [SUM_BITS-1:0]    dvx_q, dvy_q;
	logic [REM_BITS-1:0]    remx_q, remy_q;
	logic [DIVCNT_BITS-1:0] divcnt_q;

	logic [COORD_BITS-1:0] dax_q, day_q, dbx_q, dby_q;
	logic [THR_BITS-1:0]   dthr_q;
	logic                  dstrict_q;
	state_t                dret_q;
	logic [2:0]            dstep_q;
	logic [DX_BITS-1:0]    ex_q, ey_q;
	logic [SQ_BITS-1:0]    acc_q;
	logic                  dres_q;

	result_t res_q [MAX_RES];
	logic [NRES_BITS-1:0] nres_q, oidx_q;
	logic    out_valid_q;
	result_t out_q;
	logic    out_last_q;

	// combinational helpers
	logic [TC_BITS-1:0]    walk_nx;
	logic [RAW_BITS-1:0]   raw_inc;
	logic [TICK_BITS-1:0]  idle_inc;
	logic [RT_BITS-1:0]    rthr;
	logic [DX_BITS-1:0]    mul_a, mul_b;
	logic [2*DX_BITS-1:0]  mul_p;
	logic [REM_BITS-1:0]   remx_sh, remy_sh;
	logic [SUM_BITS-1:0]   dvx_sh, dvy_sh;
	logic [DIR_BITS-1:0]   pan_dir;
	logic                  had_scroll;

	assign walk_nx  = walk_q + 1'b1;
	assign raw_inc  = (raw_q == '1) ? raw_q : raw_q + 1'b1;
	assign idle_inc = (idle_q == '1) ? idle_q : idle_q + 1'b1;
	assign rthr     = {dthr_q, {COORD_BITS{1'b0}}} - RT_BITS'(dthr_q);
	assign had_scroll = sact_q || (sdir_q != DIR_NONE);

	// shared distance multiplier operands
	always_comb begin
		case (dstep_q)
			3'd0: begin
				mul_a = DX_BITS'(absdiff(dax_q, dbx_q));
				mul_b = DX_BITS'(win_w_q);
			end
			3'd1: begin
				mul_a = DX_BITS'(absdiff(day_q, dby_q));
				mul_b = DX_BITS'(win_h_q);
			end
			3'd2: begin
				mul_a = ex_q;
				mul_b = ex_q;
			end
			3'd3: begin
				mul_a = ey_q;
				mul_b = ey_q;
			end
			default: begin
				mul_a = DX_BITS'(rthr);
				mul_b = DX_BITS'(rthr);
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// one restoring division step for both centroid axes
	always_comb begin
		remx_sh = {remx_q[REM_BITS-2:0], dvx_q[SUM_BITS-1]};
		remy_sh = {remy_q[REM_BITS-2:0], dvy_q[SUM_BITS-1]};
		dvx_sh  = {dvx_q[SUM_BITS-2:0], 1'b0};
		dvy_sh  = {dvy_q[SUM_BITS-2:0], 1'b0};
		if (remx_sh >= REM_BITS'(tc_q)) begin
			remx_sh   = remx_sh - REM_BITS'(tc_q);
			dvx_sh[0] = 1'b1;
		end
		if (remy_sh >= REM_BITS'(tc_q)) begin
			remy_sh   = remy_sh - REM_BITS'(tc_q);
			dvy_sh[0] = 1'b1;
		end
	end

	// pan direction from the scaled centroid deltas
	always_comb begin
		logic [DX_BITS+2:0] x5, y5, x2, y2;
		logic [DIR_BITS-1:0] hdir, vdir;
		x5 = (DX_BITS+3)'(ex_q) * 3'd5;
		y5 = (DX_BITS+3)'(ey_q) * 3'd5;
		x2 = {2'b00, ex_q, 1'b0};
		y2 = {2'b00, ey_q, 1'b0};
		hdir = DIR_NONE;
		vdir = DIR_NONE;
		if (x5 > y2)
			hdir = (dbx_q > dax_q) ? DIR_W : DIR_E;
		if (y5 > x2)
			vdir = (dby_q > day_q) ? DIR_N : DIR_S;
		if (hdir == DIR_E)
			pan_dir = (vdir == DIR_N) ? DIR_NE : ((vdir == DIR_S) ? DIR_SE : DIR_E);
		else if (hdir == DIR_W)
			pan_dir = (vdir == DIR_N) ? DIR_NW : ((vdir == DIR_S) ? DIR_SW : DIR_W);
		else if (vdir != DIR_NONE)
			pan_dir = vdir;
		else
			pan_dir = sdir_q;
	end

	// table port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = tc_q[IDX_BITS-1:0];
		wr_data = '{id: fid_q, down_x: tx_q, down_y: ty_q, cur_x: tx_q, cur_y: ty_q};
		rd_addr = walk_q[IDX_BITS-1:0];
		case (state_q)
			S_DECODE: begin
				wr_en = (act_q == ACT_DOWN) && dev_q && (tc_q < TC_BITS'(MAX_FINGERS));
			end
			S_AFTER_FIND: begin
				wr_en   = (act_q == ACT_MOTION) && found_q;
				wr_addr = fidx_q;
				wr_data = ent_q;
				wr_data.cur_x = tx_q;
				wr_data.cur_y = ty_q;
			end
			S_SHIFT_RD: begin
				rd_addr = walk_nx[IDX_BITS-1:0];
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = walk_q[IDX_BITS-1:0];
				wr_data = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ftab[wr_addr] <= wr_data;
		rd_q <= ftab[rd_addr];
	end

	// sequencer, gesture state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gest_q       <= G_IDLE;
			raw_q        <= '0;
			tc_q         <= '0;
			ppx_q        <= '0;
			ppy_q        <= '0;
			idle_q       <= '0;
			sact_q       <= 1'b0;
			sdir_q       <= DIR_NONE;
			win_w_q      <= WIN_BITS'(1024);
			win_h_q      <= WIN_BITS'(768);
			drag_thr_q   <= THR_BITS'(10);
			two_thr_q    <= THR_BITS'(10);
			pan_step_q   <= THR_BITS'(8);
			idle_ticks_q <= TICK_BITS'(100);
			act_q        <= ACT_TICK;
			dev_q        <= 1'b0;
			fid_q        <= '0;
			tx_q         <= '0;
			ty_q         <= '0;
			walk_q       <= '0;
			found_q      <= 1'b0;
			fidx_q       <= '0;
			ent_q        <= '0;
			lx_q         <= '0;
			ly_q         <= '0;
			sx_q         <= '0;
			sy_q         <= '0;
			dvx_q        <= '0;
			dvy_q        <= '0;
			remx_q       <= '0;
			remy_q       <= '0;
			divcnt_q     <= '0;
			dax_q        <= '0;
			day_q        <= '0;
			dbx_q        <= '0;
			dby_q        <= '0;
			dthr_q       <= '0;
			dstrict_q    <= 1'b0;
			dret_q       <= S_IDLE;
			dstep_q      <= '0;
			ex_q         <= '0;
			ey_q         <= '0;
			acc_q        <= '0;
			dres_q       <= 1'b0;
			for (int i = 0; i < MAX_RES; i++)
				res_q[i] <= '0;
			nres_q       <= '0;
			oidx_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_WIN_W:      win_w_q      <= cfg_data[WIN_BITS-1:0];
					CFG_WIN_H:      win_h_q      <= cfg_data[WIN_BITS-1:0];
					CFG_DRAG_THR:   drag_thr_q   <= cfg_data[THR_BITS-1:0];
					CFG_TWO_THR:    two_thr_q    <= cfg_data[THR_BITS-1:0];
					CFG_PAN_STEP:   pan_step_q   <= cfg_data[THR_BITS-1:0];
					CFG_IDLE_TICKS: idle_ticks_q <= cfg_data[TICK_BITS-1:0];
					default: ;
				endcase
			end

			// output transfer frees the register
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action_t'(action);
						dev_q   <= direct_device;
						fid_q   <= finger_id;
						tx_q    <= touch_x;
						ty_q    <= touch_y;
						nres_q  <= '0;
						oidx_q  <= '0;
						found_q <= 1'b0;
						walk_q  <= '0;
						state_q <= S_DECODE;
					end
				end

				S_DECODE: begin
					state_q <= S_DRAIN;
					if (act_q == ACT_TICK) begin
						if (gest_q == G_PANNING) begin
							idle_q <= idle_inc;
							if (sact_q && (idle_inc > idle_ticks_q)) begin
								sact_q   <= 1'b0;
								res_q[0] <= mk_res(K_SCROLL, BTN_LEFT, '0, '0, 1'b0, sdir_q);
								nres_q   <= NRES_BITS'(1);
							end
						end
					end else if (dev_q) begin
						case (act_q)
							ACT_DOWN: begin
								raw_q <= raw_inc;
								if (tc_q < TC_BITS'(MAX_FINGERS))
									tc_q <= tc_q + 1'b1;
								if (raw_inc == RAW_BITS'(1)) begin
									gest_q <= G_PENDING;
								end else if (raw_inc == RAW_BITS'(2)) begin
									gest_q <= G_TWO;
								end else if (raw_inc == RAW_BITS'(3)) begin
									gest_q  <= G_PANNING;
									idle_q  <= '0;
									sx_q    <= '0;
									sy_q    <= '0;
									state_q <= S_CEN_RD;
								end else begin
									gest_q <= G_CANCELLED;
								end
							end
							default: begin
								if ((act_q == ACT_UP) && (raw_q != '0))
									raw_q <= raw_q - 1'b1;
								state_q <= (tc_q == '0) ? S_AFTER_FIND : S_FIND_RD;
							end
						endcase
					end
				end

				// first matching id in the table
				S_FIND_RD: begin
					state_q <= S_FIND_CHK;
				end

				S_FIND_CHK: begin
					if (rd_q.id == fid_q) begin
						found_q <= 1'b1;
						fidx_q  <= walk_q[IDX_BITS-1:0];
						ent_q   <= rd_q;
						state_q <= S_AFTER_FIND;
					end else if (walk_nx >= tc_q) begin
						state_q <= S_AFTER_FIND;
					end else begin
						walk_q  <= walk_nx;
						state_q <= S_FIND_RD;
					end
				end

				S_AFTER_FIND: begin
					state_q <= S_DRAIN;
					if (act_q == ACT_MOTION) begin
						case (gest_q)
							G_PENDING, G_TWO: begin
								if (found_q) begin
									dax_q     <= ent_q.down_x;
									day_q     <= ent_q.down_y;
									dbx_q     <= tx_q;
									dby_q     <= ty_q;
									dthr_q    <= (gest_q == G_PENDING) ? drag_thr_q : two_thr_q;
									dstrict_q <= 1'b1;
									dret_q    <= (gest_q == G_PENDING) ? S_M_PEND : S_M_TWO;
									dstep_q   <= '0;
									state_q   <= S_DIST;
								end
							end
							G_DRAGGING: begin
								if (found_q) begin
									res_q[0] <= mk_res(K_MOVE, BTN_LEFT, tx_q, ty_q, 1'b0, DIR_NONE);
									nres_q   <= NRES_BITS'(1);
								end
							end
							G_PANNING: begin
								walk_q  <= '0;
								sx_q    <= '0;
								sy_q    <= '0;
								state_q <= S_CEN_RD;
							end
							default: ;
						endcase
					end else begin
						// finger lift
						walk_q  <= TC_BITS'(fidx_q);
						state_q <= found_q ? S_SHIFT_RD : S_LIFT_END;
						case (gest_q)
							G_PENDING: begin
								res_q[0] <= mk_res(K_MOVE, BTN_LEFT,
									found_q ? ent_q.down_x : tx_q,
									found_q ? ent_q.down_y : ty_q, 1'b0, DIR_NONE);
								res_q[1] <= mk_res(K_PRESS, BTN_LEFT,
									found_q ? ent_q.down_x : tx_q,
									found_q ? ent_q.down_y : ty_q, 1'b0, DIR_NONE);
								res_q[2] <= mk_res(K_RELEASE, BTN_LEFT,
									found_q ? ent_q.down_x : tx_q,
									found_q ? ent_q.down_y : ty_q, 1'b0, DIR_NONE);
								res_q[3] <= mk_res(K_RERAISE, BTN_LEFT, '0, '0, 1'b0, DIR_NONE);
								nres_q   <= NRES_BITS'(4);
								gest_q   <= G_CANCELLED;
							end
							G_DRAGGING: begin
								res_q[0] <= mk_res(K_MOVE, BTN_LEFT,
									found_q ? ent_q.cur_x : tx_q,
									found_q ? ent_q.cur_y : ty_q, 1'b0, DIR_NONE);
								res_q[1] <= mk_res(K_RELEASE, BTN_LEFT,
									found_q ? ent_q.cur_x : tx_q,
									found_q ? ent_q.cur_y : ty_q, 1'b0, DIR_NONE);
								nres_q   <= NRES_BITS'(2);
								gest_q   <= G_CANCELLED;
							end
							G_TWO: begin
								lx_q <= tx_q;
								ly_q <= ty_q;
								if (tc_q != '0) begin
									walk_q  <= '0;
									state_q <= S_LEFT_RD;
								end else begin
									state_q <= S_U_TWO;
								end
							end
							G_PANNING: begin
								sact_q   <= 1'b0;
								sdir_q   <= DIR_NONE;
								res_q[0] <= mk_res(K_SCROLL, BTN_LEFT, '0, '0, 1'b0, DIR_NONE);
								nres_q   <= NRES_BITS'(1);
								gest_q   <= G_CANCELLED;
							end
							default: ;
						endcase
					end
				end

				// leftmost tracked finger for the right click
				S_LEFT_RD: begin
					state_q <= S_LEFT_CHK;
				end

				S_LEFT_CHK: begin
					if ((walk_q == '0) || (rd_q.cur_x < lx_q)) begin
						lx_q <= rd_q.cur_x;
						ly_q <= rd_q.cur_y;
					end
					if (walk_nx >= tc_q) begin
						state_q <= S_U_TWO;
					end else begin
						walk_q  <= walk_nx;
						state_q <= S_LEFT_RD;
					end
				end

				S_U_TWO: begin
					res_q[0] <= mk_res(K_MOVE, BTN_LEFT, lx_q, ly_q, 1'b0, DIR_NONE);
					res_q[1] <= mk_res(K_PRESS, BTN_RIGHT, lx_q, ly_q, 1'b0, DIR_NONE);
					res_q[2] <= mk_res(K_RELEASE, BTN_RIGHT, lx_q, ly_q, 1'b0, DIR_NONE);
					nres_q   <= NRES_BITS'(3);
					gest_q   <= G_CANCELLED;
					walk_q   <= TC_BITS'(fidx_q);
					state_q  <= found_q ? S_SHIFT_RD : S_LIFT_END;
				end

				// close the gap left by the lifted finger
				S_SHIFT_RD: begin
					if (walk_nx < tc_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						tc_q    <= tc_q - 1'b1;
						state_q <= S_LIFT_END;
					end
				end

				S_SHIFT_WR: begin
					walk_q  <= walk_nx;
					state_q <= S_SHIFT_RD;
				end

				S_LIFT_END: begin
					if (raw_q == '0) begin
						tc_q   <= '0;
						sact_q <= 1'b0;
						sdir_q <= DIR_NONE;
						gest_q <= G_IDLE;
						if (had_scroll && (nres_q < NRES_BITS'(MAX_RES))) begin
							res_q[nres_q[1:0]] <= mk_res(K_SCROLL, BTN_LEFT, '0, '0, 1'b0,
								DIR_NONE);
							nres_q <= nres_q + 1'b1;
						end
					end
					state_q <= S_DRAIN;
				end

				// centroid sum over the table
				S_CEN_RD: begin
					state_q <= (tc_q == '0) ? S_CEN_DONE : S_CEN_ADD;
				end

				S_CEN_ADD: begin
					sx_q <= sx_q + SUM_BITS'(rd_q.cur_x);
					sy_q <= sy_q + SUM_BITS'(rd_q.cur_y);
					if (walk_nx >= tc_q) begin
						dvx_q    <= sx_q + SUM_BITS'(rd_q.cur_x) + SUM_BITS'(tc_q >> 1);
						dvy_q    <= sy_q + SUM_BITS'(rd_q.cur_y) + SUM_BITS'(tc_q >> 1);
						remx_q   <= '0;
						remy_q   <= '0;
						divcnt_q <= '0;
						state_q  <= S_DIV;
					end else begin
						walk_q  <= walk_nx;
						state_q <= S_CEN_RD;
					end
				end

				S_DIV: begin
					dvx_q    <= dvx_sh;
					dvy_q    <= dvy_sh;
					remx_q   <= remx_sh;
					remy_q   <= remy_sh;
					divcnt_q <= divcnt_q + 1'b1;
					if (divcnt_q == DIVCNT_BITS'(SUM_BITS - 1))
						state_q <= S_CEN_DONE;
				end

				S_CEN_DONE: begin
					state_q <= S_DRAIN;
					if (tc_q != '0) begin
						if (act_q == ACT_DOWN) begin
							ppx_q <= dvx_q[COORD_BITS-1:0];
							ppy_q <= dvy_q[COORD_BITS-1:0];
						end else begin
							dax_q     <= ppx_q;
							day_q     <= ppy_q;
							dbx_q     <= dvx_q[COORD_BITS-1:0];
							dby_q     <= dvy_q[COORD_BITS-1:0];
							dthr_q    <= pan_step_q;
							dstrict_q <= 1'b0;
							dret_q    <= S_M_PAN;
							dstep_q   <= '0;
							state_q   <= S_DIST;
						end
					end
				end

				// scaled squared distance against squared threshold
				S_DIST: begin
					dstep_q <= dstep_q + 1'b1;
					case (dstep_q)
						3'd0: ex_q  <= mul_p[DX_BITS-1:0];
						3'd1: ey_q  <= mul_p[DX_BITS-1:0];
						3'd2: acc_q <= SQ_BITS'(mul_p);
						3'd3: acc_q <= acc_q + SQ_BITS'(mul_p);
						default: begin
							dres_q  <= dstrict_q ? (acc_q > SQ_BITS'(mul_p))
							                     : (acc_q >= SQ_BITS'(mul_p));
							state_q <= dret_q;
						end
					endcase
				end

				S_M_PEND: begin
					if (dres_q) begin
						res_q[0] <= mk_res(K_MOVE, BTN_LEFT, ent_q.down_x, ent_q.down_y, 1'b0,
							DIR_NONE);
						res_q[1] <= mk_res(K_PRESS, BTN_LEFT, ent_q.down_x, ent_q.down_y, 1'b0,
							DIR_NONE);
						res_q[2] <= mk_res(K_MOVE, BTN_LEFT, tx_q, ty_q, 1'b0, DIR_NONE);
						nres_q   <= NRES_BITS'(3);
						gest_q   <= G_DRAGGING;
					end
					state_q <= S_DRAIN;
				end

				S_M_TWO: begin
					if (dres_q)
						gest_q <= G_CANCELLED;
					state_q <= S_DRAIN;
				end

				S_M_PAN: begin
					if (dres_q) begin
						sdir_q   <= pan_dir;
						sact_q   <= 1'b1;
						ppx_q    <= dbx_q;
						ppy_q    <= dby_q;
						idle_q   <= '0;
						res_q[0] <= mk_res(K_SCROLL, BTN_LEFT, '0, '0, 1'b1, pan_dir);
						nres_q   <= NRES_BITS'(1);
					end
					state_q <= S_DRAIN;
				end

				// hand results to the output register
				S_DRAIN: begin
					if (oidx_q == nres_q) begin
						state_q <= S_IDLE;
					end else if (!out_valid_q || out_ready) begin
						out_q       <= res_q[oidx_q[1:0]];
						out_last_q  <= ((oidx_q + 1'b1) == nres_q);
						out_valid_q <= 1'b1;
						oidx_q      <= oidx_q + 1'b1;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign kind       = out_q.kind;
	assign button     = out_q.button;
	assign pos_x      = out_q.x;
	assign pos_y      = out_q.y;
	assign scroll_on  = out_q.on;
	assign scroll_dir = out_q.dir;
	assign last       = out_last_q;

	a_tc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tc_q <= TC_BITS'(MAX_FINGERS))
		else $error("tracked count above table depth");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(gest_q == G_IDLE) |-> ((tc_q == '0) && (raw_q == '0)))
		else $error("idle gesture with fingers counted");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= NRES_BITS'(MAX_RES))
		else $error("result buffer overrun");

	a_scroll_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.kind != K_SCROLL)) |-> (!out_q.on && (out_q.dir == DIR_NONE)))
		else $error("scroll fields set on a non-scroll result");

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DRAIN) && (oidx_q == nres_q) && (nres_q != '0)) |-> out_last_q)
		else $error("final result not marked last");

endmodule
